// ===== src/ppp_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the pinhole point projection block
// no dependencies

package ppp_pkg;

  localparam int COORD_W     = 32;
  localparam int INTENSITY_W = 16;
  localparam int DIM_W       = 13;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_IDX_W   = 3;
  localparam int PROD_W      = 64;
  localparam int MAG_W       = 64;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(512);
  localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(612);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_P00_P01 = 3'd0,
    REG_P02_P03 = 3'd1,
    REG_P10_P11 = 3'd2,
    REG_P12_P13 = 3'd3,
    REG_P20_P21 = 3'd4,
    REG_P22_P23 = 3'd5,
    REG_WIDTH   = 3'd6,
    REG_HEIGHT  = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
  } row_sum_t;

endpackage

// ===== src/ppp_if.sv =====
`timescale 1ns / 1ps
// request channels for points in and pixels out
// depends on ppp_pkg

interface ppp_point_if
  import ppp_pkg::*;
#(
  parameter int INDEX_BITS = 20
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_W-1:0]     point_x;
  logic signed [COORD_W-1:0]     point_y;
  logic signed [COORD_W-1:0]     point_z;
  logic        [INTENSITY_W-1:0] point_intensity;
  logic        [INDEX_BITS-1:0]  point_index;

  modport source (output valid, point_x, point_y, point_z, point_intensity, point_index,
                  input ready);
  modport sink (input valid, point_x, point_y, point_z, point_intensity, point_index,
                output ready);
endinterface

interface ppp_pixel_if
  import ppp_pkg::*;
#(
  parameter int INDEX_BITS = 20,
  parameter int PIXEL_BITS = 12
);
  logic                   valid;
  logic                   ready;
  logic                   keep;
  logic [PIXEL_BITS-1:0]  pixel_col;
  logic [PIXEL_BITS-1:0]  pixel_row;
  logic [INTENSITY_W-1:0] out_intensity;
  logic [INDEX_BITS-1:0]  out_index;

  modport source (output valid, keep, pixel_col, pixel_row, out_intensity, out_index,
                  input ready);
  modport sink (input valid, keep, pixel_col, pixel_row, out_intensity, out_index,
                output ready);
endinterface

// ===== src/ppp_row_mac.sv =====
`timescale 1ns / 1ps
// one matrix row times the homogeneous point, four register stages
// depends on ppp_pkg

module ppp_row_mac
  import ppp_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [CFG_DATA_W-1:0]     coef_lo_i,
  input  logic [CFG_DATA_W-1:0]     coef_hi_i,
  input  logic signed [COORD_W-1:0] x_i,
  input  logic signed [COORD_W-1:0] y_i,
  input  logic signed [COORD_W-1:0] z_i,
  output row_sum_t                  sum_o
);

  logic signed [PROD_W-1:0] p_q [4];
  logic signed [PROD_W:0]   a_q, b_q;
  logic signed [PROD_W+1:0] s_q;
  logic        [PROD_W+1:0] s_neg;
  row_sum_t                 sum_q;

  assign s_neg = -s_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // products
      p_q[0] <= $signed(coef_lo_i[31:0]) * x_i;
      p_q[1] <= $signed(coef_lo_i[63:32]) * y_i;
      p_q[2] <= $signed(coef_hi_i[31:0]) * z_i;
      p_q[3] <= PROD_W'($signed(coef_hi_i[63:32])) <<< FRAC_BITS;
      // pair sums
      a_q <= {p_q[0][PROD_W-1], p_q[0]} + {p_q[1][PROD_W-1], p_q[1]};
      b_q <= {p_q[2][PROD_W-1], p_q[2]} + {p_q[3][PROD_W-1], p_q[3]};
      // full sum
      s_q <= {a_q[PROD_W], a_q} + {b_q[PROD_W], b_q};
      // sign and magnitude
      sum_q.neg <= s_q[PROD_W+1];
      sum_q.mag <= s_q[PROD_W+1] ? s_neg[MAG_W-1:0] : s_q[MAG_W-1:0];
    end
  end

  assign sum_o = sum_q;

endmodule

// ===== src/ppp_axis_div.sv =====
`timescale 1ns / 1ps
// pipelined restoring divide, rounding and border check for one axis
// depends on ppp_pkg

module ppp_axis_div
  import ppp_pkg::*;
#(
  parameter int PIXEL_BITS = 12,
  parameter int BORDER     = 2
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  row_sum_t              num_i,
  input  row_sum_t              den_i,
  input  logic [DIM_W-1:0]      limit_i,
  output logic                  ok_o,
  output logic [PIXEL_BITS-1:0] pix_o
);

  localparam int QB = PIXEL_BITS + 1;
  localparam int CW = ((QB + 1 > DIM_W) ? QB + 1 : DIM_W) + 2;

  logic [MAG_W-1:0] r_q    [QB+1];
  logic [MAG_W-1:0] d_q    [QB+1];
  logic [QB-1:0]    q_q    [QB+1];
  logic [QB-1:0]    nlow_q [QB+1];
  logic             sgn_q  [QB+1];
  logic             bad_q  [QB+1];

  logic [MAG_W-1:0] r_init;
  logic             ok_q;
  logic [PIXEL_BITS-1:0] pix_q;

  assign r_init = num_i.mag >> QB;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]    <= r_init;
      d_q[0]    <= den_i.mag;
      q_q[0]    <= '0;
      nlow_q[0] <= num_i.mag[QB-1:0];
      sgn_q[0]  <= num_i.neg ^ den_i.neg;
      // quotient too wide or zero depth
      bad_q[0]  <= (r_init >= den_i.mag) || (den_i.mag == '0);
    end
  end

  for (genvar k = 1; k <= QB; k++) begin : g_step
    logic [MAG_W:0] t;
    logic [MAG_W:0] diff;
    logic           ge;

    assign t    = {r_q[k-1], nlow_q[k-1][QB-k]};
    assign ge   = t >= {1'b0, d_q[k-1]};
    assign diff = t - {1'b0, d_q[k-1]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[k]    <= ge ? diff[MAG_W-1:0] : t[MAG_W-1:0];
        q_q[k]    <= {q_q[k-1][QB-2:0], ge};
        d_q[k]    <= d_q[k-1];
        nlow_q[k] <= nlow_q[k-1];
        sgn_q[k]  <= sgn_q[k-1];
        bad_q[k]  <= bad_q[k-1];
      end
    end
  end

  logic          rnd;
  logic [CW-1:0] qr;
  logic          ok_d;

  always_comb begin
    rnd  = {r_q[QB], 1'b0} >= {1'b0, d_q[QB]};
    qr   = CW'(q_q[QB]) + CW'(rnd);
    ok_d = !bad_q[QB]
         && !(sgn_q[QB] && (qr != '0))
         && (qr >= CW'(BORDER))
         && ((qr + CW'(BORDER)) <= CW'(limit_i))
         && (qr < (CW'(1) << PIXEL_BITS));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ok_q  <= ok_d;
      pix_q <= ok_d ? qr[PIXEL_BITS-1:0] : '0;
    end
  end

  assign ok_o  = ok_q;
  assign pix_o = pix_q;

endmodule

// ===== src/pinhole_point_projection.sv =====
`timescale 1ns / 1ps
// top level of the pinhole point projection block
// depends on ppp_pkg, ppp_if, ppp_row_mac and ppp_axis_div

// Projects one lidar point per unstalled clock through a 3x4 matrix and divides
// by depth. Fully pipelined: one point is taken every unstalled cycle and each
// result passes through 4 multiply/sum stages, one divider setup stage,
// PIXEL_BITS + 1 one-bit divide stages, a rounding stage and the output
// register. The whole pipe holds when the output is stalled. The user must
// write configuration only with the pipe empty; the block does not enforce it.

module pinhole_point_projection
  import ppp_pkg::*;
#(
  parameter int FRAC_BITS  = 16,
  parameter int INDEX_BITS = 20,
  parameter int PIXEL_BITS = 12,
  parameter int BORDER     = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  ppp_point_if.sink             point_i,
  ppp_pixel_if.source           pixel_o
);

  localparam int LAT = 4 + (PIXEL_BITS + 3) + 1;

  logic [CFG_DATA_W-1:0] coef_q [6];
  logic [DIM_W-1:0]      width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) coef_q[i] <= '0;
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_P00_P01: coef_q[0] <= cfg_data_i;
        REG_P02_P03: coef_q[1] <= cfg_data_i;
        REG_P10_P11: coef_q[2] <= cfg_data_i;
        REG_P12_P13: coef_q[3] <= cfg_data_i;
        REG_P20_P21: coef_q[4] <= cfg_data_i;
        REG_P22_P23: coef_q[5] <= cfg_data_i;
        REG_WIDTH:   width_q   <= cfg_data_i[DIM_W-1:0];
        REG_HEIGHT:  height_q  <= cfg_data_i[DIM_W-1:0];
        default:     ;
      endcase
    end
  end

  logic en;
  logic v_q [LAT];
  logic [INTENSITY_W-1:0] int_q [LAT];
  logic [INDEX_BITS-1:0]  idx_q [LAT];

  assign en            = !v_q[LAT-1] || pixel_o.ready;
  assign point_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LAT; i++) v_q[i] <= 1'b0;
    end else if (en) begin
      v_q[0] <= point_i.valid;
      for (int i = 1; i < LAT; i++) v_q[i] <= v_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      int_q[0] <= point_i.point_intensity;
      idx_q[0] <= point_i.point_index;
      for (int i = 1; i < LAT; i++) begin
        int_q[i] <= int_q[i-1];
        idx_q[i] <= idx_q[i-1];
      end
    end
  end

  row_sum_t sum_u, sum_v, sum_w;

  ppp_row_mac #(.FRAC_BITS(FRAC_BITS)) u_mac_u (
    .clk_i, .en_i(en), .coef_lo_i(coef_q[0]), .coef_hi_i(coef_q[1]),
    .x_i(point_i.point_x), .y_i(point_i.point_y), .z_i(point_i.point_z), .sum_o(sum_u)
  );

  ppp_row_mac #(.FRAC_BITS(FRAC_BITS)) u_mac_v (
    .clk_i, .en_i(en), .coef_lo_i(coef_q[2]), .coef_hi_i(coef_q[3]),
    .x_i(point_i.point_x), .y_i(point_i.point_y), .z_i(point_i.point_z), .sum_o(sum_v)
  );

  ppp_row_mac #(.FRAC_BITS(FRAC_BITS)) u_mac_w (
    .clk_i, .en_i(en), .coef_lo_i(coef_q[4]), .coef_hi_i(coef_q[5]),
    .x_i(point_i.point_x), .y_i(point_i.point_y), .z_i(point_i.point_z), .sum_o(sum_w)
  );

  logic                  ok_col, ok_row;
  logic [PIXEL_BITS-1:0] pix_col, pix_row;

  ppp_axis_div #(.PIXEL_BITS(PIXEL_BITS), .BORDER(BORDER)) u_div_col (
    .clk_i, .en_i(en), .num_i(sum_u), .den_i(sum_w), .limit_i(width_q),
    .ok_o(ok_col), .pix_o(pix_col)
  );

  ppp_axis_div #(.PIXEL_BITS(PIXEL_BITS), .BORDER(BORDER)) u_div_row (
    .clk_i, .en_i(en), .num_i(sum_v), .den_i(sum_w), .limit_i(height_q),
    .ok_o(ok_row), .pix_o(pix_row)
  );

  logic                  keep_q;
  logic [PIXEL_BITS-1:0] col_q, row_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      keep_q <= ok_col && ok_row;
      col_q  <= (ok_col && ok_row) ? pix_col : '0;
      row_q  <= (ok_col && ok_row) ? pix_row : '0;
    end
  end

  assign pixel_o.valid         = v_q[LAT-1];
  assign pixel_o.keep          = keep_q;
  assign pixel_o.pixel_col     = col_q;
  assign pixel_o.pixel_row     = row_q;
  assign pixel_o.out_intensity = int_q[LAT-1];
  assign pixel_o.out_index     = idx_q[LAT-1];

endmodule
